[design/slot_allocator_mark_sweep_macros.svh]
// assertion macros used by the slot allocator top level
// needs clk and rst_n in the scope where a macro is used
`ifndef SLOT_ALLOCATOR_MARK_SWEEP_MACROS_SVH
`define SLOT_ALLOCATOR_MARK_SWEEP_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define SAM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge, off during reset
`define SAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sam_pkg.sv]
// shared sizes, codes and types of the slot allocator
// no dependencies
package sam_pkg;

    localparam int SLOTS     = 1024;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int WORDS     = SLOTS / WORD_BITS;
    localparam int WADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_MARK    = 2'd1,
        OP_COLLECT = 2'd2,
        OP_SWEEP   = 2'd3
    } sam_op_t;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_OOM = 2'd1,
        STAT_DUP = 2'd2
    } sam_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOT,
        ST_TEST,
        ST_SW_RD,
        ST_SW_LOAD,
        ST_SW_BITS
    } sam_state_t;

    // requests from the sequencer to the bitmap store
    typedef struct packed {
        logic                 rd_en;
        logic [WADDR_W-1:0]   rd_addr;
        logic                 wr_en;
        logic [WADDR_W-1:0]   wr_addr;
        logic [WORD_BITS-1:0] wr_data;
        logic                 flip;
        logic                 clr_snap;
    } sam_bm_ctl_t;

endpackage

[design/sam_bitmap.sv]
// ping-pong bitmap store: one bank is the in-use map, the other the snapshot
// depends on sam_pkg
module sam_bitmap
    import sam_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sam_bm_ctl_t          ctl,
    output logic [WORD_BITS-1:0] inuse_word,
    output logic [WORD_BITS-1:0] snap_word
);

    logic                 sel_reg;
    logic                 sel_next;
    logic [WORDS-1:0]     vld0_reg;
    logic [WORDS-1:0]     vld0_next;
    logic [WORDS-1:0]     vld1_reg;
    logic [WORDS-1:0]     vld1_next;
    logic                 rv0_reg;
    logic                 rv1_reg;
    logic [WORD_BITS-1:0] rd0_reg;
    logic [WORD_BITS-1:0] rd1_reg;
    logic [WORD_BITS-1:0] mem0 [WORDS];
    logic [WORD_BITS-1:0] mem1 [WORDS];
    logic [WORD_BITS-1:0] word0;
    logic [WORD_BITS-1:0] word1;

    // bank select and word valid bits; a word not valid reads as zero
    always_comb
    begin
        sel_next  = sel_reg;
        vld0_next = vld0_reg;
        vld1_next = vld1_reg;
        if (ctl.flip)
        begin
            sel_next = ~sel_reg;
            if (sel_reg)
                vld0_next = '0;
            else
                vld1_next = '0;
        end
        else if (ctl.clr_snap)
        begin
            if (sel_reg)
                vld0_next = '0;
            else
                vld1_next = '0;
        end
        if (ctl.wr_en)
        begin
            if (sel_reg)
                vld1_next[ctl.wr_addr] = 1'b1;
            else
                vld0_next[ctl.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg  <= 1'b0;
            vld0_reg <= '0;
            vld1_reg <= '0;
            rv0_reg  <= 1'b0;
            rv1_reg  <= 1'b0;
        end
        else
        begin
            sel_reg  <= sel_next;
            vld0_reg <= vld0_next;
            vld1_reg <= vld1_next;
            if (ctl.rd_en)
            begin
                rv0_reg <= vld0_reg[ctl.rd_addr];
                rv1_reg <= vld1_reg[ctl.rd_addr];
            end
        end
    end

    // bank arrays, writes go to the in-use bank only
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && !sel_reg)
            mem0[ctl.wr_addr] <= ctl.wr_data;
        if (ctl.rd_en)
            rd0_reg <= mem0[ctl.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && sel_reg)
            mem1[ctl.wr_addr] <= ctl.wr_data;
        if (ctl.rd_en)
            rd1_reg <= mem1[ctl.rd_addr];
    end

    // route read data by role
    assign word0      = rd0_reg & {WORD_BITS{rv0_reg}};
    assign word1      = rd1_reg & {WORD_BITS{rv1_reg}};
    assign inuse_word = sel_reg ? word1 : word0;
    assign snap_word  = sel_reg ? word0 : word1;

endmodule

[design/slot_allocator_mark_sweep.sv]
// top level of the slot allocator: sequencer, free stack memory, result register
// depends on sam_pkg, sam_bitmap and slot_allocator_mark_sweep_macros.svh
//
// Usage: a command is transferred at a rising edge where start is high and busy
// is low; opcode selects allocate, mark, begin collection or sweep, slot_index
// names the slot to mark. Every command gives one result, shown for exactly one
// cycle with done high; the receiver cannot stall, so done is a plain strobe.
// Steps from the transfer to done: begin collection and allocate with an empty
// stack answer directly from idle; mark reads the bitmap, then writes it back;
// allocate reads the free stack, then the bitmap, then writes back. Sweep walks
// the 32-bit bitmap words: each is read, loaded as a mask, then its freed slots
// are pushed onto the free stack one per step. One command is in flight at a
// time, and the next may be transferred in the cycle where done is high.
// Reset: bitmaps read as all clear, the free stack is full and pops slots in
// ascending order; no clearing pass is needed, so start is taken at once.
module slot_allocator_mark_sweep
    import sam_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        opcode,
    input  logic [SLOT_W-1:0] slot_index,
    output logic              done,
    output logic [SLOT_W-1:0] alloc_slot,
    output logic              was_marked,
    output logic [1:0]        status,
    output logic [CNT_W-1:0]  freed_count,
    output logic [CNT_W-1:0]  free_slots
);

`include "slot_allocator_mark_sweep_macros.svh"

    sam_state_t           state_reg;
    sam_state_t           state_next;
    sam_op_t              op_reg;
    sam_op_t              op_next;
    sam_op_t              op_in;
    logic [SLOT_W-1:0]    idx_reg;
    logic [SLOT_W-1:0]    idx_next;
    logic [CNT_W-1:0]     depth_reg;
    logic [CNT_W-1:0]     depth_next;
    logic [CNT_W-1:0]     low_reg;
    logic [CNT_W-1:0]     low_next;
    logic                 init_reg;
    logic                 init_next;
    logic [WADDR_W-1:0]   word_reg;
    logic [WADDR_W-1:0]   word_next;
    logic [WORD_BITS-1:0] mask_reg;
    logic [WORD_BITS-1:0] mask_next;
    logic [CNT_W-1:0]     freed_reg;
    logic [CNT_W-1:0]     freed_next;

    logic                 done_reg;
    logic                 done_next;
    logic [SLOT_W-1:0]    alloc_slot_reg;
    logic [SLOT_W-1:0]    alloc_slot_next;
    logic                 was_marked_reg;
    logic                 was_marked_next;
    sam_status_t          status_reg;
    sam_status_t          status_next;
    logic [CNT_W-1:0]     freed_count_reg;
    logic [CNT_W-1:0]     freed_count_next;
    logic [CNT_W-1:0]     free_slots_reg;
    logic [CNT_W-1:0]     free_slots_next;

    logic                 accept;
    logic [CNT_W-1:0]     depth_dec;
    logic [SLOT_W-1:0]    slot_pick;
    logic [BIT_W-1:0]     bit_pos;
    logic                 test_bit;
    logic [BIT_W-1:0]     low_bit;
    logic                 push_ok;
    logic                 last_word;

    logic                 stk_rd_en;
    logic                 stk_wr_en;
    logic [SLOT_W-1:0]    stk_wr_data;
    logic [SLOT_W-1:0]    stk_rd_reg;
    logic [SLOT_W-1:0]    stk_mem [SLOTS];

    sam_bm_ctl_t          bm_ctl;
    logic [WORD_BITS-1:0] bm_inuse;
    logic [WORD_BITS-1:0] bm_snap;

    // position of the lowest set bit of a bitmap word
    function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] m);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (m[i])
                pos = BIT_W'(i);
        end
        return pos;
    endfunction

    sam_bitmap u_bitmap (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (bm_ctl),
        .inuse_word (bm_inuse),
        .snap_word  (bm_snap)
    );

    // shared decode
    assign accept    = start && (state_reg == ST_IDLE);
    assign op_in     = sam_op_t'(opcode);
    assign depth_dec = depth_reg - CNT_W'(1);
    // an entry below the low watermark was never pushed, so its slot is derived from the depth
    assign slot_pick = init_reg ? (SLOT_W'(SLOTS - 1) - depth_reg[SLOT_W-1:0]) : stk_rd_reg;
    assign bit_pos   = idx_reg[BIT_W-1:0];
    assign test_bit  = bm_inuse[bit_pos];
    assign low_bit   = lowest_bit(mask_reg);
    assign push_ok   = (mask_reg != '0) && (depth_reg < CNT_W'(SLOTS));
    assign last_word = (word_reg == WADDR_W'(WORDS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_in)
                        OP_ALLOC:   state_next = (depth_reg != '0) ? ST_SLOT : ST_IDLE;
                        OP_MARK:    state_next = ST_TEST;
                        OP_COLLECT: state_next = ST_IDLE;
                        OP_SWEEP:   state_next = ST_SW_RD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SLOT:    state_next = ST_TEST;
            ST_TEST:    state_next = ST_IDLE;
            ST_SW_RD:   state_next = ST_SW_LOAD;
            ST_SW_LOAD: state_next = ST_SW_BITS;
            ST_SW_BITS:
            begin
                priority if (push_ok)
                    state_next = ST_SW_BITS;
                else if (last_word)
                    state_next = ST_IDLE;
                else
                    state_next = ST_SW_RD;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath, memory requests and results
    always_comb
    begin
        op_next          = op_reg;
        idx_next         = idx_reg;
        depth_next       = depth_reg;
        low_next         = low_reg;
        init_next        = init_reg;
        word_next        = word_reg;
        mask_next        = mask_reg;
        freed_next       = freed_reg;
        done_next        = 1'b0;
        alloc_slot_next  = alloc_slot_reg;
        was_marked_next  = was_marked_reg;
        status_next      = status_reg;
        freed_count_next = freed_count_reg;
        free_slots_next  = free_slots_reg;
        stk_rd_en        = 1'b0;
        stk_wr_en        = 1'b0;
        stk_wr_data      = (SLOT_W'(word_reg) << BIT_W) | SLOT_W'(low_bit);
        bm_ctl           = '0;
        bm_ctl.wr_addr   = WADDR_W'(idx_reg >> BIT_W);
        bm_ctl.wr_data   = bm_inuse | (WORD_BITS'(1) << bit_pos);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next = op_in;
                    unique case (op_in)
                        OP_ALLOC:
                        begin
                            if (depth_reg == '0)
                            begin
                                done_next        = 1'b1;
                                alloc_slot_next  = '0;
                                was_marked_next  = 1'b0;
                                status_next      = STAT_OOM;
                                freed_count_next = '0;
                                free_slots_next  = depth_reg;
                            end
                            else
                            begin
                                // pop: read the new top entry
                                depth_next = depth_dec;
                                stk_rd_en  = 1'b1;
                                init_next  = (depth_dec < low_reg);
                                if (depth_dec < low_reg)
                                    low_next = depth_dec;
                            end
                        end
                        OP_MARK:
                        begin
                            idx_next       = slot_index;
                            bm_ctl.rd_en   = 1'b1;
                            bm_ctl.rd_addr = WADDR_W'(slot_index >> BIT_W);
                        end
                        OP_COLLECT:
                        begin
                            bm_ctl.flip      = 1'b1;
                            done_next        = 1'b1;
                            alloc_slot_next  = '0;
                            was_marked_next  = 1'b0;
                            status_next      = STAT_OK;
                            freed_count_next = '0;
                            free_slots_next  = depth_reg;
                        end
                        OP_SWEEP:
                        begin
                            word_next  = '0;
                            freed_next = '0;
                        end
                        default:
                        begin
                            op_next = op_reg;
                        end
                    endcase
                end
            end
            ST_SLOT:
            begin
                idx_next       = slot_pick;
                bm_ctl.rd_en   = 1'b1;
                bm_ctl.rd_addr = WADDR_W'(slot_pick >> BIT_W);
            end
            ST_TEST:
            begin
                // write back the word with the slot bit set
                bm_ctl.wr_en     = 1'b1;
                done_next        = 1'b1;
                freed_count_next = '0;
                free_slots_next  = depth_reg;
                if (op_reg == OP_ALLOC)
                begin
                    alloc_slot_next = idx_reg;
                    was_marked_next = 1'b0;
                    status_next     = test_bit ? STAT_DUP : STAT_OK;
                end
                else
                begin
                    alloc_slot_next = '0;
                    was_marked_next = test_bit;
                    status_next     = STAT_OK;
                end
            end
            ST_SW_RD:
            begin
                bm_ctl.rd_en   = 1'b1;
                bm_ctl.rd_addr = word_reg;
            end
            ST_SW_LOAD:
            begin
                mask_next = bm_snap & ~bm_inuse;
            end
            ST_SW_BITS:
            begin
                if (push_ok)
                begin
                    // push the lowest freed slot of this word
                    stk_wr_en  = 1'b1;
                    depth_next = depth_reg + CNT_W'(1);
                    freed_next = freed_reg + CNT_W'(1);
                    mask_next  = mask_reg & (mask_reg - WORD_BITS'(1));
                end
                else
                begin
                    mask_next = '0;
                    if (last_word)
                    begin
                        bm_ctl.clr_snap  = 1'b1;
                        done_next        = 1'b1;
                        alloc_slot_next  = '0;
                        was_marked_next  = 1'b0;
                        status_next      = STAT_OK;
                        freed_count_next = freed_reg;
                        free_slots_next  = depth_reg;
                    end
                    else
                    begin
                        word_next = word_reg + WADDR_W'(1);
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            depth_reg <= CNT_W'(SLOTS);
            low_reg   <= CNT_W'(SLOTS);
            init_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            low_reg   <= low_next;
            init_reg  <= init_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        idx_reg         <= idx_next;
        word_reg        <= word_next;
        mask_reg        <= mask_next;
        freed_reg       <= freed_next;
        alloc_slot_reg  <= alloc_slot_next;
        was_marked_reg  <= was_marked_next;
        status_reg      <= status_next;
        freed_count_reg <= freed_count_next;
        free_slots_reg  <= free_slots_next;
    end

    // free stack memory
    always_ff @(posedge clk)
    begin
        if (stk_wr_en)
            stk_mem[depth_reg[SLOT_W-1:0]] <= stk_wr_data;
        if (stk_rd_en)
            stk_rd_reg <= stk_mem[depth_dec[SLOT_W-1:0]];
    end

    // ports
    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign alloc_slot  = alloc_slot_reg;
    assign was_marked  = was_marked_reg;
    assign status      = status_reg;
    assign freed_count = freed_count_reg;
    assign free_slots  = free_slots_reg;

    // checks
    `SAM_ASSERT_IMPL(a_depth_max, 1'b1, depth_reg <= CNT_W'(SLOTS), "free depth above pool size")
    `SAM_ASSERT_IMPL(a_low_mark, 1'b1, low_reg <= depth_reg, "low watermark above free depth")
    `SAM_ASSERT_IMPL(a_done_src, done_reg, $past(busy) || $past(start), "result without a command")
    `SAM_ASSERT_NEXT(a_oom, accept && (op_in == OP_ALLOC) && (depth_reg == '0),
                     done_reg && (status_reg == STAT_OOM), "empty stack not reported")

endmodule
